[hw/rtl/brmt_pkg.sv]
// Shared types and codes for the bracket range match tree unit.
// No dependencies.
package brmt_pkg;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_L_RD,
		S_L_WR,
		S_Q_CHK,
		S_QL_JN,
		S_Q_R,
		S_QR_JN,
		S_Q_FIN,
		S_OUT
	} state_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

[hw/rtl/bracket_range_match_tree_unit.sv]
// Top level of the bracket range match tree: node memory, sequencer, output register.
// Depends on brmt_pkg and brmt_join.
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready req_type position symbol_open | in
//          | range_start range_end                           |
//  out     | out_valid out_ready matched_length range_error  | out
//
// Load: writes the leaf, then per tree level reads the sibling and combines it into
// the parent, up to the root.
// Query: per level of the range walk, a bound check and optional left and right joins,
// then a final combine. A bad range goes straight out. One combiner serves all steps.
// After reset a clearing pass (TB = LEAVES rounded up to a power of two) writes every
// node; in_ready stays low meanwhile.
// A finished result waits in the output register; the next item is taken meanwhile.
module bracket_range_match_tree_unit #(
	parameter int LEAVES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [9:0]  position,
	input  logic        symbol_open,
	input  logic [9:0]  range_start,
	input  logic [9:0]  range_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] matched_length,
	output logic        range_error
);
	import brmt_pkg::*;

	localparam int LB  = $clog2(LEAVES);
	localparam int TB  = 1 << LB;
	localparam int NAW = LB + 1;
	localparam int CW  = LB + 1;
	localparam int SW  = 3 * CW;

	state_t state_q, state_d;

	logic [SW-1:0]  mem [2*TB];
	logic [SW-1:0]  rdata_q;
	logic [NAW-1:0] raddr, waddr;
	logic [SW-1:0]  wdata;
	logic           we;

	logic [NAW-1:0] ci_q, ci_d;
	logic [CW-1:0]  span_q, span_d;
	logic [NAW:0]   l_q, l_d, r_q, r_d;
	logic [SW-1:0]  cur_q, cur_d, accl_q, accl_d, accr_q, accr_d;
	logic [10:0]    res_m_q, res_m_d;
	logic           res_e_q, res_e_d;
	logic           ov_q, ov_d;
	logic [10:0]    om_q, om_d;
	logic           oe_q, oe_d;

	logic [SW-1:0]  ja, jb, jy;
	logic           acc;
	logic [NAW:0]   ci_next;

	brmt_join #(.CW(CW)) u_join (.a(ja), .b(jb), .y(jy));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign in_ready       = (state_q == S_IDLE);
	assign acc            = in_valid && in_ready;
	assign out_valid      = ov_q;
	assign matched_length = om_q;
	assign range_error    = oe_q;
	assign ci_next        = {1'b0, ci_q} + 1'b1;

	always_comb begin
		state_d = state_q;
		ci_d    = ci_q;
		span_d  = span_q;
		l_d     = l_q;
		r_d     = r_q;
		cur_d   = cur_q;
		accl_d  = accl_q;
		accr_d  = accr_q;
		res_m_d = res_m_q;
		res_e_d = res_e_q;
		ov_d    = ov_q && !out_ready;
		om_d    = om_q;
		oe_d    = oe_q;
		raddr   = '0;
		waddr   = '0;
		wdata   = '0;
		we      = 1'b0;
		ja      = accl_q;
		jb      = accr_q;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = ci_q;
				wdata = {{CW{1'b0}}, span_q, {CW{1'b0}}};
				ci_d  = ci_next[NAW-1:0];
				// halve the span on entering the next level
				if ((ci_next[NAW-1:0] & ci_q) == '0) begin
					span_d = span_q >> 1;
				end
				if (ci_q == NAW'(2*TB-1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc) begin
					if (req_type == REQ_LOAD) begin
						if (32'(position) < LEAVES) begin
							we      = 1'b1;
							waddr   = NAW'(TB) + NAW'(position);
							wdata   = {{CW{1'b0}}, CW'(symbol_open), CW'(!symbol_open)};
							cur_d   = wdata;
							l_d     = (NAW+1)'(TB) + (NAW+1)'(position);
							state_d = S_L_RD;
						end
					end else if (range_start > range_end || 32'(range_end) >= LEAVES) begin
						res_m_d = '0;
						res_e_d = 1'b1;
						state_d = S_OUT;
					end else begin
						l_d     = (NAW+1)'(TB) + (NAW+1)'(range_start);
						r_d     = (NAW+1)'(TB) + (NAW+1)'(range_end) + 1'b1;
						accl_d  = '0;
						accr_d  = '0;
						state_d = S_Q_CHK;
					end
				end
			end
			S_L_RD: begin
				raddr = l_q[NAW-1:0] ^ NAW'(1);
				if (l_q == (NAW+1)'(1)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_L_WR;
				end
			end
			S_L_WR: begin
				ja      = l_q[0] ? rdata_q : cur_q;
				jb      = l_q[0] ? cur_q : rdata_q;
				we      = 1'b1;
				waddr   = l_q[NAW:1];
				wdata   = jy;
				cur_d   = jy;
				l_d     = l_q >> 1;
				state_d = S_L_RD;
			end
			S_Q_CHK: begin
				if (l_q >= r_q) begin
					state_d = S_Q_FIN;
				end else if (l_q[0]) begin
					raddr   = l_q[NAW-1:0];
					state_d = S_QL_JN;
				end else begin
					state_d = S_Q_R;
				end
			end
			S_QL_JN: begin
				ja      = accl_q;
				jb      = rdata_q;
				accl_d  = jy;
				l_d     = l_q + 1'b1;
				state_d = S_Q_R;
			end
			S_Q_R: begin
				if (r_q[0]) begin
					raddr   = r_q[NAW-1:0] - 1'b1;
					r_d     = r_q - 1'b1;
					state_d = S_QR_JN;
				end else begin
					l_d     = l_q >> 1;
					r_d     = r_q >> 1;
					state_d = S_Q_CHK;
				end
			end
			S_QR_JN: begin
				ja      = rdata_q;
				jb      = accr_q;
				accr_d  = jy;
				l_d     = l_q >> 1;
				r_d     = r_q >> 1;
				state_d = S_Q_CHK;
			end
			S_Q_FIN: begin
				ja      = accl_q;
				jb      = accr_q;
				res_m_d = 11'(jy[SW-1:2*CW]);
				res_e_d = 1'b0;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the output register frees up
				if (!ov_q || out_ready) begin
					ov_d    = 1'b1;
					om_d    = res_m_q;
					oe_d    = res_e_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ci_q    <= NAW'(1);
			span_q  <= CW'(TB);
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ci_q    <= ci_d;
			span_q  <= span_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		l_q     <= l_d;
		r_q     <= r_d;
		cur_q   <= cur_d;
		accl_q  <= accl_d;
		accr_q  <= accr_d;
		res_m_q <= res_m_d;
		res_e_q <= res_e_d;
		om_q    <= om_d;
		oe_q    <= oe_d;
	end

	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("input taken during clearing pass");
	a_left_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QL_JN) |-> (l_q < r_q))
		else $error("left node read past right bound");
	a_load_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_L_WR) |-> (l_q > (NAW+1)'(1)))
		else $error("load walk combined above root");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && ov_q && !out_ready) |=> (state_q == S_OUT))
		else $error("result dropped while output stalled");
endmodule

[hw/rtl/brmt_join.sv]
// Span combiner: pairs left unmatched opens with right unmatched closes.
// Packed span is {matched, opens, closes}. No dependencies.
module brmt_join #(
	parameter int CW = 11
) (
	input  logic [3*CW-1:0] a,
	input  logic [3*CW-1:0] b,
	output logic [3*CW-1:0] y
);
	logic [CW-1:0] am, ao, ac, bm, bo, bc, p, ym, yo, yc;

	always_comb begin
		{am, ao, ac} = a;
		{bm, bo, bc} = b;
		p  = (ao < bc) ? ao : bc;
		ym = am + bm + {p[CW-2:0], 1'b0};
		yo = ao + bo - p;
		yc = ac + bc - p;
		y  = {ym, yo, yc};
	end
endmodule
